// ----- rtl/afr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afr_pkg: shared types and constants of the ASCII frame receiver
// Field widths, register indexes, event codes and the hex digit decoder.
// ----------------------------------------------------------------------------
package afr_pkg;

    localparam int MAX_PAYLOAD = 32;
    localparam int IDX_W       = $clog2(MAX_PAYLOAD);
    localparam int COUNT_W     = 6;
    localparam int IDLE_W      = 17;
    localparam int TIMEOUT_W   = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int READ_IDX_W  = 5;

    localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(MAX_PAYLOAD);

    // Item kinds carried on s_tuser
    localparam logic [1:0] MODE_BYTE  = 2'd0;
    localparam logic [1:0] MODE_TICK  = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;
    localparam logic [1:0] MODE_READ  = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SYNC_CHAR    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SEPARATOR    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_END_A        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_END_B        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RX_TIMEOUT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LOST_TIMEOUT = 3'd5;

    // Event codes
    localparam logic [3:0] EV_NONE     = 4'd0;
    localparam logic [3:0] EV_SYNC     = 4'd1;
    localparam logic [3:0] EV_RESYNC   = 4'd2;
    localparam logic [3:0] EV_OK_NOCK  = 4'd3;
    localparam logic [3:0] EV_CK_OK    = 4'd4;
    localparam logic [3:0] EV_CK_BAD   = 4'd5;
    localparam logic [3:0] EV_OVERFLOW = 4'd6;
    localparam logic [3:0] EV_TIMEOUT  = 4'd7;
    localparam logic [3:0] EV_LOST     = 4'd8;

    typedef struct packed {
        logic [7:0]           sync_char;
        logic [7:0]           separator;
        logic [7:0]           end_a;
        logic [7:0]           end_b;
        logic [TIMEOUT_W-1:0] rx_timeout;
        logic [TIMEOUT_W-1:0] lost_timeout;
    } afr_cfg_t;

    typedef struct packed {
        logic [1:0]            mode;
        logic [7:0]            data_byte;
        logic [READ_IDX_W-1:0] read_index;
    } afr_item_t;

    typedef struct packed {
        logic                byte_refused;
        logic [7:0]          read_data;
        logic [COUNT_W-1:0]  message_length;
        logic                message_ready;
        logic [3:0]          event_res;
        logic [2:0]          frame_state;
    } afr_result_t;

    // ASCII hex digit value; anything that is not 0-9 or A-F counts as zero
    function automatic logic [3:0] hex_digit(input logic [7:0] b);
        logic [3:0] v;
        v = 4'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            v = b[3:0];
        end else if (b >= 8'h41 && b <= 8'h46) begin
            v = {1'b0, b[2:0]} + 4'd9;
        end
        return v;
    endfunction

endpackage

// ----- rtl/afr_rx_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afr_rx_core: frame state machine, payload store and result register
// Updates the frame state for one item per advance and registers its result.
// ----------------------------------------------------------------------------
module afr_rx_core
    import afr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        advance,
    input  afr_item_t   item,
    input  afr_cfg_t    cfg,
    output afr_result_t result_reg
);

    typedef enum logic [2:0] {
        PH_WAIT  = 3'd0,
        PH_RECV  = 3'd1,
        PH_CHECK = 3'd2,
        PH_HELD  = 3'd3,
        PH_LOST  = 3'd4
    } phase_t;

    phase_t             phase_reg, phase_next, phase_eff;
    logic [COUNT_W-1:0] count_reg, count_next, count_eff;
    logic [7:0]         xor_reg, xor_next, xor_eff;
    logic [7:0]         check_reg, check_next, check_eff;
    logic [IDLE_W-1:0]  idle_reg, idle_next, idle_inc;
    logic [7:0]         store_mem [MAX_PAYLOAD];
    logic               store_we;
    logic               read_hit;
    logic               is_sync, is_sep, is_end;
    afr_result_t        result_next;

    assign is_sync  = item.data_byte == cfg.sync_char;
    assign is_sep   = item.data_byte == cfg.separator;
    assign is_end   = item.data_byte == cfg.end_a || item.data_byte == cfg.end_b;
    assign idle_inc = (&idle_reg) ? idle_reg : idle_reg + IDLE_W'(1);

    // A byte in lost link restarts from wait sync with cleared counters
    always_comb begin
        if (phase_reg == PH_LOST) begin
            phase_eff = PH_WAIT;
            count_eff = '0;
            xor_eff   = '0;
            check_eff = '0;
        end else begin
            phase_eff = phase_reg;
            count_eff = count_reg;
            xor_eff   = xor_reg;
            check_eff = check_reg;
        end
    end

    always_comb begin
        phase_next  = phase_reg;
        count_next  = count_reg;
        xor_next    = xor_reg;
        check_next  = check_reg;
        idle_next   = idle_reg;
        store_we    = 1'b0;
        read_hit    = 1'b0;
        result_next = '0;
        case (item.mode)
            MODE_BYTE: begin
                idle_next  = '0;
                phase_next = phase_eff;
                count_next = count_eff;
                xor_next   = xor_eff;
                check_next = check_eff;
                case (phase_eff)
                    PH_WAIT: begin
                        if (is_sync) begin
                            phase_next            = PH_RECV;
                            count_next            = '0;
                            xor_next              = '0;
                            check_next            = '0;
                            result_next.event_res = EV_SYNC;
                        end
                    end
                    PH_RECV: begin
                        if (is_sync) begin
                            count_next            = '0;
                            xor_next              = '0;
                            check_next            = '0;
                            result_next.event_res = EV_RESYNC;
                        end else if (is_sep) begin
                            phase_next = PH_CHECK;
                        end else if (is_end) begin
                            phase_next            = PH_HELD;
                            result_next.event_res = EV_OK_NOCK;
                        end else if (count_eff < MAX_COUNT) begin
                            store_we   = 1'b1;
                            count_next = count_eff + COUNT_W'(1);
                            xor_next   = xor_eff ^ item.data_byte;
                        end else begin
                            phase_next            = PH_WAIT;
                            result_next.event_res = EV_OVERFLOW;
                        end
                    end
                    PH_CHECK: begin
                        if (is_end) begin
                            if (check_eff == xor_eff) begin
                                phase_next            = PH_HELD;
                                result_next.event_res = EV_CK_OK;
                            end else begin
                                phase_next            = PH_WAIT;
                                result_next.event_res = EV_CK_BAD;
                            end
                        end else begin
                            check_next = {check_eff[3:0], hex_digit(item.data_byte)};
                        end
                    end
                    default: begin
                        result_next.byte_refused = 1'b1;
                    end
                endcase
            end
            MODE_TICK: begin
                idle_next = idle_inc;
                if ((phase_reg == PH_RECV || phase_reg == PH_CHECK)
                        && idle_inc > IDLE_W'(cfg.rx_timeout)) begin
                    phase_next            = PH_WAIT;
                    result_next.event_res = EV_TIMEOUT;
                end else if (phase_reg != PH_LOST
                        && idle_inc > IDLE_W'(cfg.lost_timeout)) begin
                    phase_next            = PH_LOST;
                    result_next.event_res = EV_LOST;
                end
            end
            MODE_CLEAR: begin
                phase_next = PH_WAIT;
            end
            default: begin
                read_hit = COUNT_W'(item.read_index) < count_reg;
            end
        endcase
        result_next.frame_state    = phase_next;
        result_next.message_ready  = phase_next == PH_HELD;
        result_next.message_length = count_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_WAIT;
            count_reg <= '0;
            xor_reg   <= '0;
            check_reg <= '0;
            idle_reg  <= '0;
        end else if (advance) begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            xor_reg   <= xor_next;
            check_reg <= check_next;
            idle_reg  <= idle_next;
        end
    end

    // Only bytes below the current length are visible to a read
    always_ff @(posedge aclk) begin
        if (advance) begin
            result_reg.frame_state    <= result_next.frame_state;
            result_reg.event_res      <= result_next.event_res;
            result_reg.message_ready  <= result_next.message_ready;
            result_reg.message_length <= result_next.message_length;
            result_reg.byte_refused   <= result_next.byte_refused;
            result_reg.read_data      <= read_hit ?
                                         store_mem[item.read_index[IDX_W-1:0]] : 8'd0;
            if (store_we) begin
                store_mem[count_eff[IDX_W-1:0]] <= item.data_byte;
            end
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= MAX_COUNT)
        else $error("payload count above capacity");

    a_refuse_held: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && item.mode == MODE_BYTE && phase_reg == PH_HELD
        |=> result_reg.byte_refused && phase_reg == PH_HELD)
        else $error("byte in held state not refused");

    a_byte_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && item.mode == MODE_BYTE |=> idle_reg == '0)
        else $error("idle count not cleared by a byte");

    a_ck_match: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(advance) && result_reg.event_res == EV_CK_OK
        |-> check_reg == xor_reg && phase_reg == PH_HELD)
        else $error("checksum ok without matching checksum");

endmodule

// ----- rtl/ascii_frame_receiver_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascii_frame_receiver_top: ASCII frame receiver with XOR checksum
// Parses sync / payload / separator / hex checksum / end frames from a byte
// stream, holds a good message and serves reads of its payload.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream carries one item per transaction: s_tuser selects the
//   kind (received byte, one millisecond tick, clear, read) and s_tdata holds
//   the byte and the read index. Every accepted item yields exactly one result
//   transaction on the master stream with the frame state, event code, message
//   status and read data.
//   The result is registered in the output register on the clock edge that
//   accepts the item. Throughput is one item per cycle while the master side
//   does not stall; the state update is a single pass of logic into that register.
//   When the master side stalls, the output register holds the result and
//   s_tready drops until it is taken; s_tready rises again in the same cycle
//   as m_tready, so the stream keeps moving without bubbles.
//   The configuration channel is always ready; write it only while the
//   stream is idle. Indexes above the last register are ignored.
//   Reset (aresetn low, synchronous) returns the parser to wait sync, clears
//   counters and the idle tick count, and loads default characters and
//   timeouts. Payload storage is not cleared; only bytes below the current
//   length are ever returned.
// ----------------------------------------------------------------------------
module ascii_frame_receiver_top
    import afr_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // slave stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [15:0]           s_tdata,  // data_byte[7:0], read_index[12:8], zero
    input  logic [1:0]            s_tuser,  // mode[1:0]
    // master stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [23:0]           m_tdata   // frame_state[2:0], event_res[6:3],
                                            // message_ready[7], message_length[13:8],
                                            // read_data[21:14], byte_refused[22], zero
);

    afr_cfg_t    cfg_reg;
    afr_item_t   item;
    afr_result_t result;
    logic        m_tvalid_reg;
    logic        advance;

    // Registers are plain flops; the channel never stalls
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sync_char    <= 8'd36;
            cfg_reg.separator    <= 8'd42;
            cfg_reg.end_a        <= 8'd13;
            cfg_reg.end_b        <= 8'd10;
            cfg_reg.rx_timeout   <= 16'd1000;
            cfg_reg.lost_timeout <= 16'd5000;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_SYNC_CHAR:    cfg_reg.sync_char    <= cfg_data[7:0];
                REG_SEPARATOR:    cfg_reg.separator    <= cfg_data[7:0];
                REG_END_A:        cfg_reg.end_a        <= cfg_data[7:0];
                REG_END_B:        cfg_reg.end_b        <= cfg_data[7:0];
                REG_RX_TIMEOUT:   cfg_reg.rx_timeout   <= cfg_data;
                REG_LOST_TIMEOUT: cfg_reg.lost_timeout <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Unpack the slave transaction
    assign item.mode       = s_tuser;
    assign item.data_byte  = s_tdata[7:0];
    assign item.read_index = s_tdata[12:8];

    // Take a new item whenever the output register is empty or being drained
    assign s_tready = !m_tvalid_reg || m_tready;
    assign advance  = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (advance) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    afr_rx_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .advance    (advance),
        .item       (item),
        .cfg        (cfg_reg),
        .result_reg (result)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, result};

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stream-level check of the ASCII frame receiver
// Drives byte, tick, clear and read transactions with random stalls on both
// sides and compares every result transaction with a cycle-free predictor of
// the frame parser. The run covers a directed table, random framed traffic
// under several character and timeout settings, and a short lost-link run.
// ----------------------------------------------------------------------------
module testbench;
    import afr_pkg::*;

    localparam int LIMIT_CYCLES = 1_000_000;
    localparam int HOLD_CYCLES  = 400;
    localparam int LOST_TICKS   = 12;
    localparam int BLOCK_ITEMS  = 100;
    localparam int NUM_BLOCKS   = 16;
    localparam logic [IDLE_W-1:0] IDLE_SAT = '1;

    typedef enum logic [2:0] {ST_WAIT, ST_RECV, ST_CHECK, ST_HELD, ST_LOST} phase_t;

    // one row of the directed table: a register write or a stream item
    typedef struct {
        bit                    is_reg;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        afr_item_t             item;
        bit                    typed;
        afr_result_t           want;
    } row_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [15:0]           s_tdata;   // data_byte[7:0], read_index[12:8], zero
    logic [1:0]            s_tuser;   // mode[1:0]
    logic                  m_tvalid;
    logic                  m_tready;
    logic [23:0]           m_tdata;   // frame_state, event_res, message_ready,
                                      // message_length, read_data, byte_refused, zero

    // parser prediction state
    afr_cfg_t           cfg_now;
    phase_t             ph;
    logic [7:0]         pay_mem [MAX_PAYLOAD];
    logic [COUNT_W-1:0] pay_len;
    logic [7:0]         xor_acc;
    logic [7:0]         ck_acc;
    logic [IDLE_W-1:0]  idle_cnt;

    afr_result_t pending_results [$];
    row_t        dir_rows [$];

    int src_idle_pct;
    int dst_idle_pct;
    int hold_left;
    int n_fail;
    int items_sent;
    int cycle_count;

    ascii_frame_receiver_top u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #6 aclk = ~aclk;

    // value of one checksum character; anything outside 0-9 and A-F is zero
    function automatic logic [3:0] nibble_of(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) begin
            return c[3:0];
        end else if (c >= 8'h41 && c <= 8'h46) begin
            return c[3:0] + 4'd9;
        end
        return 4'd0;
    endfunction

    function automatic logic [7:0] hex_ascii(input logic [3:0] v);
        return (v < 4'd10) ? 8'h30 + 8'(v) : 8'h37 + 8'(v);
    endfunction

    function automatic void drop_payload();
        pay_len = '0;
        xor_acc = '0;
        ck_acc  = '0;
    endfunction

    // advance the parser by one item and return the result it produces
    function automatic afr_result_t parse_item(input afr_item_t it);
        afr_result_t r;
        logic [7:0]  b;
        bit          is_end;
        r      = '0;
        b      = it.data_byte;
        is_end = (b == cfg_now.end_a) || (b == cfg_now.end_b);
        case (it.mode)
            MODE_BYTE: begin
                idle_cnt = '0;
                if (ph == ST_LOST) begin
                    drop_payload();
                    ph = ST_WAIT;
                end
                case (ph)
                    ST_WAIT: begin
                        if (b == cfg_now.sync_char) begin
                            drop_payload();
                            ph = ST_RECV;
                            r.event_res = EV_SYNC;
                        end
                    end
                    ST_RECV: begin
                        // sync wins over separator, separator over end bytes
                        if (b == cfg_now.sync_char) begin
                            drop_payload();
                            r.event_res = EV_RESYNC;
                        end else if (b == cfg_now.separator) begin
                            ph = ST_CHECK;
                        end else if (is_end) begin
                            ph = ST_HELD;
                            r.event_res = EV_OK_NOCK;
                        end else if (pay_len < MAX_COUNT) begin
                            pay_mem[pay_len[IDX_W-1:0]] = b;
                            pay_len = pay_len + 1'b1;
                            xor_acc = xor_acc ^ b;
                        end else begin
                            ph = ST_WAIT;
                            r.event_res = EV_OVERFLOW;
                        end
                    end
                    ST_CHECK: begin
                        if (is_end) begin
                            if (ck_acc == xor_acc) begin
                                ph = ST_HELD;
                                r.event_res = EV_CK_OK;
                            end else begin
                                ph = ST_WAIT;
                                r.event_res = EV_CK_BAD;
                            end
                        end else begin
                            ck_acc = {ck_acc[3:0], nibble_of(b)};
                        end
                    end
                    default: r.byte_refused = 1'b1;
                endcase
            end
            MODE_TICK: begin
                if (idle_cnt != IDLE_SAT) begin
                    idle_cnt = idle_cnt + 1'b1;
                end
                if ((ph == ST_RECV || ph == ST_CHECK) && idle_cnt > cfg_now.rx_timeout) begin
                    ph = ST_WAIT;
                    r.event_res = EV_TIMEOUT;
                end else if (ph != ST_LOST && idle_cnt > cfg_now.lost_timeout) begin
                    ph = ST_LOST;
                    r.event_res = EV_LOST;
                end
            end
            MODE_CLEAR: ph = ST_WAIT;
            default: begin
                if (COUNT_W'(it.read_index) < pay_len) begin
                    r.read_data = pay_mem[it.read_index];
                end
            end
        endcase
        r.frame_state    = ph;
        r.message_ready  = (ph == ST_HELD);
        r.message_length = pay_len;
        return r;
    endfunction

    function automatic void add_row(input logic [1:0] mode, input logic [7:0] b,
                                    input logic [4:0] idx);
        row_t row;
        row = '{default: '0};
        row.item = '{mode: mode, data_byte: b, read_index: idx};
        dir_rows.push_back(row);
    endfunction

    function automatic void add_typed(input logic [1:0] mode, input logic [7:0] b,
                                      input logic [4:0] idx, input phase_t st,
                                      input logic [3:0] ev, input logic [5:0] len,
                                      input logic [7:0] rd, input logic refused);
        row_t row;
        row = '{default: '0};
        row.item  = '{mode: mode, data_byte: b, read_index: idx};
        row.typed = 1'b1;
        row.want  = '{byte_refused: refused, read_data: rd, message_length: len,
                      message_ready: (st == ST_HELD), event_res: ev, frame_state: st};
        dir_rows.push_back(row);
    endfunction

    function automatic void add_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] val);
        row_t row;
        row = '{default: '0};
        row.is_reg  = 1'b1;
        row.reg_idx = idx;
        row.reg_val = val;
        dir_rows.push_back(row);
    endfunction

    task automatic cmp_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want) begin
            n_fail++;
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
        end
    endtask

    task automatic check_result(input afr_result_t got);
        afr_result_t want;
        if (pending_results.size() == 0) begin
            n_fail++;
            $error("result transaction with no item waiting for it");
        end else begin
            want = pending_results.pop_front();
            cmp_field("frame_state", 8'(want.frame_state), 8'(got.frame_state));
            cmp_field("event_res", 8'(want.event_res), 8'(got.event_res));
            cmp_field("message_ready", 8'(want.message_ready), 8'(got.message_ready));
            cmp_field("message_length", 8'(want.message_length), 8'(got.message_length));
            cmp_field("read_data", want.read_data, got.read_data);
            cmp_field("byte_refused", 8'(want.byte_refused), 8'(got.byte_refused));
        end
    endtask

    // offer one item, hold it until accepted, then log its expected result
    task automatic send_item(input logic [1:0] mode, input logic [7:0] b,
                             input logic [4:0] idx, input bit typed = 1'b0,
                             input afr_result_t want = '0);
        afr_item_t   it;
        afr_result_t pred;
        it = '{mode: mode, data_byte: b, read_index: idx};
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {3'b000, idx, b};
        do @(posedge aclk); while (s_tready !== 1'b1);
        pred = parse_item(it);
        pending_results.push_back(typed ? want : pred);
        items_sent++;
    endtask

    // drop valid and let every outstanding result drain
    task automatic wait_quiet();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (3) @(posedge aclk);
    endtask

    // leaves cfg_valid high so back-to-back writes need no second assignment
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        case (idx)
            REG_SYNC_CHAR:    cfg_now.sync_char    = val[7:0];
            REG_SEPARATOR:    cfg_now.separator    = val[7:0];
            REG_END_A:        cfg_now.end_a        = val[7:0];
            REG_END_B:        cfg_now.end_b        = val[7:0];
            REG_RX_TIMEOUT:   cfg_now.rx_timeout   = val;
            REG_LOST_TIMEOUT: cfg_now.lost_timeout = val;
            default: ;
        endcase
    endtask

    task automatic apply_setting(input int k);
        logic [7:0]  sy, sp, ea, eb, hi;
        logic [15:0] rt, lt;
        hi = 8'h00;
        case (k)
            0: begin sy = 8'h24; sp = 8'h2A; ea = 8'h0D; eb = 8'h0A; rt = 16'd8; lt = 16'd30; end
            1: begin sy = 8'h00; sp = 8'hFF; ea = 8'h7E; eb = 8'h80; rt = 16'd0; lt = 16'd0; end
            2: begin
                sy = 8'hFF; sp = 8'h00; ea = 8'h01; eb = 8'hFE;
                rt = 16'hFFFF; lt = 16'hFFFF;
            end
            // separator equal to sync and both end bytes equal
            3: begin sy = 8'h53; sp = 8'h53; ea = 8'h0A; eb = 8'h0A; rt = 16'd3; lt = 16'd6; end
            default: begin
                sy = 8'($urandom_range(255));
                sp = 8'($urandom_range(255));
                ea = 8'($urandom_range(255));
                eb = 8'($urandom_range(255));
                rt = 16'($urandom_range(30));
                lt = 16'($urandom_range(60));
                hi = 8'($urandom_range(255));
            end
        endcase
        wait_quiet();
        write_reg(REG_SYNC_CHAR, {hi, sy});
        write_reg(REG_SEPARATOR, {hi, sp});
        write_reg(REG_END_A, {hi, ea});
        write_reg(REG_END_B, {hi, eb});
        write_reg(REG_RX_TIMEOUT, rt);
        write_reg(REG_LOST_TIMEOUT, lt);
        cfg_valid <= 1'b0;
    endtask

    // random traffic, mostly well-formed frames with random content
    task automatic run_block(input int n_items);
        int         stop_at, pick, len, n, i, idx_r;
        logic [7:0] b, x;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 60) begin
                send_item(MODE_BYTE, cfg_now.sync_char, 5'($urandom_range(31)));
                pick = $urandom_range(99);
                len  = (pick < 70) ? $urandom_range(8) :
                       (pick < 90) ? $urandom_range(31, 9) : $urandom_range(34, 32);
                x = 8'h00;
                for (i = 0; i < len; i++) begin
                    do b = 8'($urandom_range(255));
                    while (b == cfg_now.sync_char || b == cfg_now.separator ||
                           b == cfg_now.end_a || b == cfg_now.end_b);
                    x = x ^ b;
                    send_item(MODE_BYTE, b, 5'($urandom_range(31)));
                    if ($urandom_range(49) == 0) begin
                        send_item(MODE_TICK, 8'($urandom_range(255)), 5'($urandom_range(31)));
                    end
                    if ($urandom_range(99) == 0) begin
                        send_item(MODE_BYTE, cfg_now.sync_char, 5'($urandom_range(31)));
                        x = 8'h00;
                    end
                end
                pick = $urandom_range(99);
                if (pick >= 40) begin
                    send_item(MODE_BYTE, cfg_now.separator, 5'($urandom_range(31)));
                    if (pick < 85) begin
                        // an extra leading digit shifts out of the eight bits kept
                        if ($urandom_range(4) == 0) begin
                            send_item(MODE_BYTE, hex_ascii(4'($urandom_range(15))),
                                      5'($urandom_range(31)));
                        end
                        send_item(MODE_BYTE, hex_ascii(x[7:4]), 5'($urandom_range(31)));
                        send_item(MODE_BYTE, hex_ascii(x[3:0]), 5'($urandom_range(31)));
                    end else begin
                        n = $urandom_range(3);
                        for (i = 0; i < n; i++) begin
                            if ($urandom_range(1) == 1) begin
                                b = hex_ascii(4'($urandom_range(15)));
                            end else begin
                                do b = 8'($urandom_range(255));
                                while (b == cfg_now.end_a || b == cfg_now.end_b);
                            end
                            send_item(MODE_BYTE, b, 5'($urandom_range(31)));
                        end
                    end
                end
                send_item(MODE_BYTE, ($urandom_range(1) == 1) ? cfg_now.end_a : cfg_now.end_b,
                          5'($urandom_range(31)));
                n = $urandom_range(3);
                for (i = 0; i < n; i++) begin
                    idx_r = (pay_len != 0 && $urandom_range(3) != 0) ?
                            $urandom_range(int'(pay_len) - 1) : $urandom_range(31);
                    send_item(MODE_READ, 8'($urandom_range(255)), 5'(idx_r));
                end
                if ($urandom_range(99) < 20) begin
                    send_item(MODE_BYTE, 8'($urandom_range(255)), 5'($urandom_range(31)));
                end
                if ($urandom_range(99) < 70) begin
                    send_item(MODE_CLEAR, 8'($urandom_range(255)), 5'($urandom_range(31)));
                end
            end else if (pick < 72) begin
                n = $urandom_range(40, 1);
                for (i = 0; i < n; i++) begin
                    send_item(MODE_TICK, 8'($urandom_range(255)), 5'($urandom_range(31)));
                end
            end else if (pick < 85) begin
                send_item(MODE_READ, 8'($urandom_range(255)), 5'($urandom_range(31)));
                if ($urandom_range(99) < 30) begin
                    send_item(MODE_CLEAR, 8'($urandom_range(255)), 5'($urandom_range(31)));
                end
            end else begin
                n = $urandom_range(6, 1);
                for (i = 0; i < n; i++) begin
                    send_item(2'($urandom_range(3)), 8'($urandom_range(255)),
                              5'($urandom_range(31)));
                end
            end
        end
    endtask

    // result side: check each accepted transaction, then pick the next ready
    always @(posedge aclk) begin
        if (aresetn && m_tvalid === 1'b1 && m_tready) begin
            check_result(afr_result_t'(m_tdata[$bits(afr_result_t)-1:0]));
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= dst_idle_pct);
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        int k, blk;
        aclk         = 1'b0;
        aresetn      = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = '0;
        m_tready     = 1'b0;
        hold_left    = 0;
        n_fail       = 0;
        items_sent   = 0;
        cycle_count  = 0;
        src_idle_pct = 11;
        dst_idle_pct = 74;

        cfg_now  = '{8'd36, 8'd42, 8'd13, 8'd10, 16'd1000, 16'd5000};
        ph       = ST_WAIT;
        pay_len  = '0;
        xor_acc  = '0;
        ck_acc   = '0;
        idle_cnt = '0;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // directed table, default framing characters '$' '*' CR LF
        add_typed(MODE_READ, 8'h00, 5'd0, ST_WAIT, EV_NONE, 6'd0, 8'd0, 1'b0);
        add_typed(MODE_BYTE, 8'h00, 5'd31, ST_WAIT, EV_NONE, 6'd0, 8'd0, 1'b0);
        add_typed(MODE_BYTE, 8'hFF, 5'd0, ST_WAIT, EV_NONE, 6'd0, 8'd0, 1'b0);
        add_typed(MODE_BYTE, 8'h24, 5'd0, ST_RECV, EV_SYNC, 6'd0, 8'd0, 1'b0);
        add_row(MODE_BYTE, 8'h41, 5'd0);
        add_typed(MODE_BYTE, 8'h24, 5'd0, ST_RECV, EV_RESYNC, 6'd0, 8'd0, 1'b0);
        add_row(MODE_BYTE, 8'h31, 5'd0);
        add_row(MODE_BYTE, 8'h32, 5'd0);
        add_row(MODE_BYTE, 8'h2A, 5'd0);
        add_row(MODE_BYTE, 8'h30, 5'd0);
        add_row(MODE_BYTE, 8'h33, 5'd0);
        add_typed(MODE_BYTE, 8'h0D, 5'd0, ST_HELD, EV_CK_OK, 6'd2, 8'd0, 1'b0);
        add_row(MODE_READ, 8'h00, 5'd1);
        add_typed(MODE_READ, 8'h00, 5'd31, ST_HELD, EV_NONE, 6'd2, 8'd0, 1'b0);
        add_typed(MODE_BYTE, 8'h55, 5'd0, ST_HELD, EV_NONE, 6'd2, 8'd0, 1'b1);
        add_typed(MODE_CLEAR, 8'h00, 5'd0, ST_WAIT, EV_NONE, 6'd2, 8'd0, 1'b0);
        // lowercase and other non-hex characters count as zero
        add_row(MODE_BYTE, 8'h24, 5'd0);
        add_row(MODE_BYTE, 8'h61, 5'd0);
        add_row(MODE_BYTE, 8'h2A, 5'd0);
        add_row(MODE_BYTE, 8'h46, 5'd0);
        add_row(MODE_BYTE, 8'h66, 5'd0);
        add_typed(MODE_BYTE, 8'h0A, 5'd0, ST_WAIT, EV_CK_BAD, 6'd1, 8'd0, 1'b0);
        add_row(MODE_BYTE, 8'h24, 5'd0);
        add_typed(MODE_BYTE, 8'h0A, 5'd0, ST_HELD, EV_OK_NOCK, 6'd0, 8'd0, 1'b0);
        add_row(MODE_CLEAR, 8'h00, 5'd0);
        add_reg(REG_RX_TIMEOUT, 16'd0);
        add_reg(REG_LOST_TIMEOUT, 16'd1);
        add_row(MODE_BYTE, 8'h24, 5'd0);
        add_typed(MODE_TICK, 8'h00, 5'd0, ST_WAIT, EV_TIMEOUT, 6'd0, 8'd0, 1'b0);
        add_typed(MODE_TICK, 8'h00, 5'd0, ST_LOST, EV_LOST, 6'd0, 8'd0, 1'b0);
        add_typed(MODE_BYTE, 8'h24, 5'd0, ST_RECV, EV_SYNC, 6'd0, 8'd0, 1'b0);

        for (k = 0; k < dir_rows.size(); k++) begin
            if (dir_rows[k].is_reg) begin
                wait_quiet();
                write_reg(dir_rows[k].reg_idx, dir_rows[k].reg_val);
            end else begin
                cfg_valid <= 1'b0;
                send_item(dir_rows[k].item.mode, dir_rows[k].item.data_byte,
                          dir_rows[k].item.read_index, dir_rows[k].typed, dir_rows[k].want);
            end
        end

        // random part: sender-light, then receiver-light, then no idling;
        // each phase opens with a long receiver hold-off to back up the input
        for (blk = 0; blk < NUM_BLOCKS; blk++) begin
            if (blk == 6) begin
                src_idle_pct = 74;
                dst_idle_pct = 11;
            end else if (blk == 11) begin
                src_idle_pct = 0;
                dst_idle_pct = 0;
            end
            apply_setting(blk % 5);
            if (blk == 0 || blk == 6 || blk == 11) begin
                hold_left = HOLD_CYCLES;
            end
            run_block(BLOCK_ITEMS);
        end

        // run the idle count past the lost-link limit, then leave lost link
        // with a clear: the next tick must raise the alarm again at once
        apply_setting(3);
        for (k = 0; k < LOST_TICKS; k++) begin
            send_item(MODE_TICK, 8'($urandom_range(255)), 5'($urandom_range(31)));
        end
        send_item(MODE_CLEAR, 8'h00, 5'd0);
        send_item(MODE_TICK, 8'h00, 5'd0);

        wait_quiet();
        repeat (4) @(posedge aclk);
        if (n_fail == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/afr_pkg.sv
rtl/afr_rx_core.sv
rtl/ascii_frame_receiver_top.sv
test/testbench.sv
